// ===== src/fra_pkg.sv =====
// ----------------------------------------------------------------------------
// fra_pkg
// shared types and constants for the fraction add and reduce block
// ----------------------------------------------------------------------------
package fra_pkg;

  // how a queued sum is to be finished by the back end
  typedef logic [1:0] fra_kind_t;

  localparam fra_kind_t KIND_REDUCE = 2'd0;  // nonzero sum, needs gcd reduction
  localparam fra_kind_t KIND_ZERO   = 2'd1;  // zero sum, result is 0/1
  localparam fra_kind_t KIND_BAD    = 2'd2;  // a denominator was zero

  // depth of the queue between front and back end
  localparam int QDEPTH = 2;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } fra_q_stat_t;

endpackage

// ===== src/fra_front.sv =====
// ----------------------------------------------------------------------------
// fra_front
// accepts operand transactions, forms the unreduced sum and classifies it
// ----------------------------------------------------------------------------
module fra_front import fra_pkg::*; #(
  parameter int W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [W-1:0]         in_first_numerator,
  input  logic [W-1:0]         in_first_denominator,
  input  logic [W-1:0]         in_second_numerator,
  input  logic [W-1:0]         in_second_denominator,
  input  fra_q_stat_t          q_stat,
  output logic                 push,
  output fra_kind_t            push_kind,
  output logic [2*W:0]         push_num,
  output logic [2*W-1:0]       push_den
);

  localparam int NW = 2 * W + 1;
  localparam int DW = 2 * W;

  logic          v1_r, v1_nxt;
  logic [W-1:0]  n1_r, d1_r, n2_r, d2_r;
  logic          v2_r, v2_nxt;
  logic [DW-1:0] p1_r, p2_r, pd_r;
  logic          bad2_r;

  logic          en1, en2;
  logic          eq_c, bad_c;
  logic [W-1:0]  sel1_c, sel2_c;
  logic [DW-1:0] p1_c, p2_c, pd_c;
  logic [NW-1:0] sum_c;

  // stage enables, stage two drains into the queue
  assign en2      = !v2_r || !q_stat.full;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign v1_nxt   = en1 ? in_valid : v1_r;
  assign v2_nxt   = en2 ? v1_r : v2_r;

  // equal denominators add over the common one, else cross multiply
  assign eq_c   = (d1_r == d2_r);
  assign bad_c  = (d1_r == '0) || (d2_r == '0);
  assign sel1_c = eq_c ? W'(1) : d2_r;
  assign sel2_c = eq_c ? W'(1) : d1_r;
  assign p1_c   = DW'(n1_r) * DW'(sel1_c);
  assign p2_c   = DW'(n2_r) * DW'(sel2_c);
  assign pd_c   = eq_c ? DW'(d1_r) : DW'(d1_r) * DW'(d2_r);

  // sum and classification feed the queue
  assign sum_c    = {1'b0, p1_r} + {1'b0, p2_r};
  assign push     = v2_r && !q_stat.full;
  assign push_num = sum_c;
  assign push_den = pd_r;

  always_comb begin
    if (bad2_r) begin
      push_kind = KIND_BAD;
    end else if (sum_c == '0) begin
      push_kind = KIND_ZERO;
    end else begin
      push_kind = KIND_REDUCE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en1) begin
      n1_r <= in_first_numerator;
      d1_r <= in_first_denominator;
      n2_r <= in_second_numerator;
      d2_r <= in_second_denominator;
    end
    if (en2) begin
      p1_r   <= p1_c;
      p2_r   <= p2_c;
      pd_r   <= pd_c;
      bad2_r <= bad_c;
    end
  end

endmodule

// ===== src/fra_queue.sv =====
// ----------------------------------------------------------------------------
// fra_queue
// short queue decoupling the front end from the gcd back end
// ----------------------------------------------------------------------------
module fra_queue import fra_pkg::*; #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fra_kind_t      push_kind,
  input  logic [2*W:0]   push_num,
  input  logic [2*W-1:0] push_den,
  input  logic           pop,
  output fra_kind_t      head_kind,
  output logic [2*W:0]   head_num,
  output logic [2*W-1:0] head_den,
  output fra_q_stat_t    q_stat
);

  localparam int NW  = 2 * W + 1;
  localparam int DW  = 2 * W;
  localparam int QPW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  fra_kind_t     kind_q [QDEPTH];
  logic [NW-1:0] num_q  [QDEPTH];
  logic [DW-1:0] den_q  [QDEPTH];

  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  // status and head of queue
  assign q_stat.full  = (count_r == QCW'(QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_kind    = kind_q[rd_ptr_r];
  assign head_num     = num_q[rd_ptr_r];
  assign head_den     = den_q[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr_r] <= push_kind;
      num_q[wr_ptr_r]  <= push_num;
      den_q[wr_ptr_r]  <= push_den;
    end
  end

endmodule

// ===== src/fra_back.sv =====
// ----------------------------------------------------------------------------
// fra_back
// binary gcd followed by two shift-subtract divisions, plus output register
// ----------------------------------------------------------------------------
module fra_back import fra_pkg::*; #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fra_q_stat_t    q_stat,
  input  fra_kind_t      head_kind,
  input  logic [2*W:0]   head_num,
  input  logic [2*W-1:0] head_den,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2*W:0]   out_sum_numerator,
  output logic [2*W-1:0] out_sum_denominator,
  output logic           out_bad_denominator
);

  localparam int NW = 2 * W + 1;
  localparam int DW = 2 * W;
  localparam int KW = $clog2(NW + 1);
  localparam int CW = $clog2(NW);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GCD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [NW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [NW-1:0] g_r, g_nxt;
  logic [NW-1:0] qn_r, qn_nxt, qd_r, qd_nxt;
  logic [NW-1:0] rn_r, rn_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          bad_r, bad_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [NW-1:0] out_num_r, out_num_nxt;
  logic [DW-1:0] out_den_r, out_den_nxt;
  logic          out_bad_r, out_bad_nxt;
  logic          out_free;
  logic [2*NW-1:0] step_n, step_d;

  // one restoring division step: returns remainder and quotient
  function automatic logic [2*NW-1:0] div_step(input logic [NW-1:0] rem,
                                               input logic [NW-1:0] quo,
                                               input logic [NW-1:0] dvs);
    logic [NW:0]   sh;
    logic [NW-1:0] rem_o;
    logic [NW-1:0] quo_o;
    sh = {rem, quo[NW-1]};
    if (sh >= {1'b0, dvs}) begin
      rem_o = NW'(sh - {1'b0, dvs});
      quo_o = {quo[NW-2:0], 1'b1};
    end else begin
      rem_o = sh[NW-1:0];
      quo_o = {quo[NW-2:0], 1'b0};
    end
    return {rem_o, quo_o};
  endfunction

  assign step_n   = div_step(rn_r, qn_r, g_r);
  assign step_d   = div_step(rd_r, qd_r, g_r);
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    qn_nxt        = qn_r;
    qd_nxt        = qd_r;
    rn_nxt        = rn_r;
    rd_nxt        = rd_r;
    cnt_nxt       = cnt_r;
    bad_nxt       = bad_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_num_nxt   = out_num_r;
    out_den_nxt   = out_den_r;
    out_bad_nxt   = out_bad_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          num_nxt = head_num;
          den_nxt = head_den;
          a_nxt   = head_num;
          b_nxt   = NW'(head_den);
          k_nxt   = '0;
          unique case (head_kind)
            KIND_BAD: begin
              qn_nxt    = '0;
              qd_nxt    = '0;
              bad_nxt   = 1'b1;
              state_nxt = S_HOLD;
            end
            KIND_ZERO: begin
              qn_nxt    = '0;
              qd_nxt    = NW'(1);
              bad_nxt   = 1'b0;
              state_nxt = S_HOLD;
            end
            default: begin
              bad_nxt   = 1'b0;
              state_nxt = S_GCD;
            end
          endcase
        end
      end
      S_GCD: begin
        // binary gcd, one halving or subtract per cycle
        if (a_r == b_r) begin
          g_nxt     = a_r << k_r;
          qn_nxt    = num_r;
          qd_nxt    = NW'(den_r);
          rn_nxt    = '0;
          rd_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + KW'(1);
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r > b_r) begin
          a_nxt = (a_r - b_r) >> 1;
        end else begin
          b_nxt = (b_r - a_r) >> 1;
        end
      end
      S_DIV: begin
        // both quotients by the gcd, one bit per cycle
        rn_nxt = step_n[2*NW-1:NW];
        qn_nxt = step_n[NW-1:0];
        rd_nxt = step_d[2*NW-1:NW];
        qd_nxt = step_d[NW-1:0];
        if (cnt_r == CW'(NW - 1)) begin
          state_nxt = S_HOLD;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_num_nxt   = qn_r;
          out_den_nxt   = qd_r[DW-1:0];
          out_bad_nxt   = bad_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    k_r       <= k_nxt;
    g_r       <= g_nxt;
    qn_r      <= qn_nxt;
    qd_r      <= qd_nxt;
    rn_r      <= rn_nxt;
    rd_r      <= rd_nxt;
    cnt_r     <= cnt_nxt;
    bad_r     <= bad_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_sum_numerator   = out_num_r;
  assign out_sum_denominator = out_den_r;
  assign out_bad_denominator = out_bad_r;

  // gcd operands never reach zero
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GCD |-> a_r != '0 && b_r != '0)
    else $error("gcd operand reached zero");

  // a finished gcd starts division with a nonzero divisor
  a_gcd_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GCD && a_r == b_r |=> state_r == S_DIV && g_r != '0)
    else $error("gcd did not hand a nonzero divisor to division");

  // division ends once its last bit is done
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r == CW'(NW - 1) |=> state_r == S_HOLD)
    else $error("division did not finish on its last bit");

  // an error result carries zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_num_r == '0 && out_den_r == '0)
    else $error("error result with nonzero fields");

endmodule

// ===== src/fraction_add_and_reduce.sv =====
// ----------------------------------------------------------------------------
// fraction_add_and_reduce
// adds two unsigned fractions and reduces the sum to lowest terms
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_stall carries the four operands of one
//   transaction; output channel out_valid/out_stall carries the reduced
//   numerator, denominator and the bad denominator flag
//   a transaction moves when valid is high and stall is low
//   the front end registers the operands, then registers the products,
//   then adds and classifies the sum and pushes it into a two-entry queue
//   the back end runs a binary gcd (one halving or subtract a cycle)
//   then divides numerator and denominator by it, one quotient bit a
//   cycle; a zero sum or a zero denominator skips the gcd and division
//   the back end handles one transaction at a time and sets the rate
//   reset empties the pipeline and the queue; results are then absent
//   while out_stall is high the result holds, the back end waits with its
//   next result and the queue and front end fill, then in_stall rises
// ----------------------------------------------------------------------------
module fraction_add_and_reduce import fra_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OPERAND_WIDTH-1:0]   in_first_numerator,
  input  logic [OPERAND_WIDTH-1:0]   in_first_denominator,
  input  logic [OPERAND_WIDTH-1:0]   in_second_numerator,
  input  logic [OPERAND_WIDTH-1:0]   in_second_denominator,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2*OPERAND_WIDTH:0]   out_sum_numerator,
  output logic [2*OPERAND_WIDTH-1:0] out_sum_denominator,
  output logic                       out_bad_denominator
);

  localparam int W = OPERAND_WIDTH;

  fra_q_stat_t    q_stat;
  logic           push, pop;
  fra_kind_t      push_kind, head_kind;
  logic [2*W:0]   push_num, head_num;
  logic [2*W-1:0] push_den, head_den;

  // operand intake and sum formation
  fra_front #(.W(W)) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_first_numerator    (in_first_numerator),
    .in_first_denominator  (in_first_denominator),
    .in_second_numerator   (in_second_numerator),
    .in_second_denominator (in_second_denominator),
    .q_stat                (q_stat),
    .push                  (push),
    .push_kind             (push_kind),
    .push_num              (push_num),
    .push_den              (push_den)
  );

  // decoupling queue
  fra_queue #(.W(W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_kind (push_kind),
    .push_num  (push_num),
    .push_den  (push_den),
    .pop       (pop),
    .head_kind (head_kind),
    .head_num  (head_num),
    .head_den  (head_den),
    .q_stat    (q_stat)
  );

  // reduction and result delivery
  fra_back #(.W(W)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .head_kind           (head_kind),
    .head_num            (head_num),
    .head_den            (head_den),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sum_numerator   (out_sum_numerator),
    .out_sum_denominator (out_sum_denominator),
    .out_bad_denominator (out_bad_denominator)
  );

endmodule
